### src/ptbl_pkg.sv
// ----------------------------------------------------------------------------
// ptbl_pkg
// Shared types and constants for the peer table: table size, derived widths,
// operation, register index and result status codes, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptbl_pkg;

  // table geometry
  localparam int TABLE_SLOTS = 8;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  // field widths
  localparam int ADDR_W   = 48;
  localparam int IDENT_W  = 8;
  localparam int TIME_W   = 32;
  localparam int STAT_W   = 3;
  localparam int SLOTF_W  = 3;
  localparam int COUNTF_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  // config reset values
  localparam logic [ADDR_W-1:0] OWN_ADDR_RESET = '0;
  localparam logic [TIME_W-1:0] EXPIRY_RESET   = 32'd60000;

  // operation codes
  localparam logic OP_HELLO = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY   = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OWN     = 3'd0,
    STAT_REFRESH = 3'd1,
    STAT_INSERT  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_SWEEP   = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // latch the item, clear scan state
    logic scan_en;  // examine one slot, advance the index
    logic commit;   // apply the update, load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic own_match;  // item at the input is a hello from our own address
    logic scan_last;  // scan index is at the last slot
  } dp_status_t;

endpackage

### src/ptbl_ctrl.sv
// ----------------------------------------------------------------------------
// ptbl_ctrl
// Sequencer for the peer table: accepts an item, steps the slot scan,
// commits the update and owns the result valid flag.
// ----------------------------------------------------------------------------
module ptbl_ctrl import ptbl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // result register can take a new result
  assign out_free = !out_valid_r || !out_stall;

  // busy outside idle, and held off during reset
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.own_match ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid: set on commit, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/ptbl_dp.sv
// ----------------------------------------------------------------------------
// ptbl_dp
// Datapath of the peer table: config registers, the slot storage, the
// one-slot-per-cycle scan (match, free search, aging) and the result register.
// ----------------------------------------------------------------------------
module ptbl_dp import ptbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_operation,
  input  logic [ADDR_W-1:0]     in_station_address,
  input  logic [IDENT_W-1:0]    in_station_id,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic [STAT_W-1:0]     out_status,
  output logic [SLOTF_W-1:0]    out_slot_index,
  output logic [COUNTF_W-1:0]   out_active_count,
  output logic [COUNTF_W-1:0]   out_expired_count
);

  // config
  logic [ADDR_W-1:0] own_addr_r;
  logic [TIME_W-1:0] expiry_r;

  // latched item
  logic              op_r;
  logic              own_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IDENT_W-1:0] id_r;
  logic [TIME_W-1:0] now_r;

  // scan state
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              hit_found_r;
  logic [SLOT_W-1:0] hit_idx_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_idx_r;
  logic [CNT_W-1:0]  expired_r;

  // table
  logic [TABLE_SLOTS-1:0] valid_r;
  logic [CNT_W-1:0]       valid_total_r, valid_total_nxt;
  logic [ADDR_W-1:0]      ent_addr_mem [TABLE_SLOTS];
  logic [IDENT_W-1:0]     ent_ident_mem [TABLE_SLOTS];
  logic [TIME_W-1:0]      ent_seen_mem [TABLE_SLOTS];

  // read data of the slot under scan
  logic [ADDR_W-1:0] rd_addr_r;
  logic [TIME_W-1:0] rd_seen_r;

  // result register
  status_t           res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [CNT_W-1:0]  res_active_r;
  logic [CNT_W-1:0]  res_expired_r;

  // current slot under scan
  logic              cur_valid;
  logic [TIME_W-1:0] cur_age;
  logic              cur_hit;
  logic              cur_free;
  logic              cur_expire;

  // commit decode
  logic    do_refresh;
  logic    do_insert;
  status_t commit_status;
  logic [SLOT_W-1:0] commit_slot;

  assign stat.own_match = (in_operation == OP_HELLO) && (in_station_address == own_addr_r);
  assign stat.scan_last = (idx_r == SLOT_W'(TABLE_SLOTS - 1));

  // scan index: cleared on accept, one step per scan cycle
  assign idx_nxt = cmd.accept ? '0 : (cmd.scan_en ? idx_r + 1'b1 : idx_r);

  assign cur_valid  = valid_r[idx_r];
  assign cur_age    = now_r - rd_seen_r;
  assign cur_hit    = cur_valid && (rd_addr_r == addr_r) && !hit_found_r;
  assign cur_free   = !cur_valid && !free_found_r;
  assign cur_expire = cur_valid && (cur_age > expiry_r);

  assign do_refresh = cmd.commit && (op_r == OP_HELLO) && !own_r && hit_found_r;
  assign do_insert  = cmd.commit && (op_r == OP_HELLO) && !own_r && !hit_found_r &&
                      free_found_r;

  // result selection
  always_comb begin
    commit_status = STAT_FULL;
    commit_slot   = '0;
    if (op_r == OP_SWEEP) begin
      commit_status = STAT_SWEEP;
    end else if (own_r) begin
      commit_status = STAT_OWN;
    end else if (hit_found_r) begin
      commit_status = STAT_REFRESH;
      commit_slot   = hit_idx_r;
    end else if (free_found_r) begin
      commit_status = STAT_INSERT;
      commit_slot   = free_idx_r;
    end
  end

  // running count of valid slots
  always_comb begin
    valid_total_nxt = valid_total_r;
    if (cmd.scan_en && (op_r == OP_SWEEP) && cur_expire) begin
      valid_total_nxt = valid_total_r - 1'b1;
    end else if (do_insert) begin
      valid_total_nxt = valid_total_r + 1'b1;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDR_RESET;
      expiry_r   <= EXPIRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDR: own_addr_r <= cfg_wdata[ADDR_W-1:0];
        REG_EXPIRY:   expiry_r   <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_operation;
      own_r  <= stat.own_match;
      addr_r <= in_station_address;
      id_r   <= in_station_id;
      now_r  <= in_now_ms;
    end
  end

  // scan control and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      hit_found_r   <= 1'b0;
      hit_idx_r     <= '0;
      free_found_r  <= 1'b0;
      free_idx_r    <= '0;
      expired_r     <= '0;
      valid_r       <= '0;
      valid_total_r <= '0;
    end else begin
      valid_total_r <= valid_total_nxt;
      idx_r         <= idx_nxt;
      if (cmd.accept) begin
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
        expired_r    <= '0;
      end else if (cmd.scan_en) begin
        if (op_r == OP_SWEEP) begin
          if (cur_expire) begin
            valid_r[idx_r] <= 1'b0;
            expired_r      <= expired_r + 1'b1;
          end
        end else begin
          if (cur_hit) begin
            hit_found_r <= 1'b1;
            hit_idx_r   <= idx_r;
          end
          if (cur_free) begin
            free_found_r <= 1'b1;
            free_idx_r   <= idx_r;
          end
        end
      end else if (do_insert) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // slot storage, no reset; read one slot ahead so data lines up with idx_r
  always_ff @(posedge clk) begin
    rd_addr_r <= ent_addr_mem[idx_nxt];
    rd_seen_r <= ent_seen_mem[idx_nxt];
    if (do_insert) begin
      ent_addr_mem[free_idx_r]  <= addr_r;
      ent_ident_mem[free_idx_r] <= id_r;
      ent_seen_mem[free_idx_r]  <= now_r;
    end else if (do_refresh) begin
      ent_seen_mem[hit_idx_r] <= now_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r  <= commit_status;
      res_slot_r    <= commit_slot;
      res_active_r  <= valid_total_nxt;
      res_expired_r <= (op_r == OP_SWEEP) ? expired_r : '0;
    end
  end

  assign out_status        = res_status_r;
  assign out_slot_index    = SLOTF_W'(res_slot_r);
  assign out_active_count  = COUNTF_W'(res_active_r);
  assign out_expired_count = COUNTF_W'(res_expired_r);

endmodule

### src/peer_table_with_aging.sv
// ----------------------------------------------------------------------------
// peer_table_with_aging
// Learning table of neighbor stations with time-based aging.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one item is a hello (in_operation = 0)
// carrying a station address, id and time, or an aging sweep (1) carrying
// the current time. Each item yields exactly one result on the output
// channel (out_valid/out_stall): status, slot, active count, expired count.
// Configuration (cfg_we/cfg_index/cfg_wdata) sets the own address (index 0)
// and the expiry timeout in ms (index 1); write only while the block is idle.
// Operation: an accepted item scans the table one slot per cycle over all
// TABLE_SLOTS slots, then commits; an own-address hello skips the scan and
// commits directly. in_stall is high whenever the block is not idle, during
// the scan and the commit, so no new item is taken until the current one
// has committed.
// A result waiting under out_stall does not block the next item; the commit
// of that item waits until the result register frees.
// Reset (rst_n low, synchronous) empties the table, clears the result valid
// flag and loads the timeout default of 60000 ms and own address zero.
// ----------------------------------------------------------------------------
module peer_table_with_aging import ptbl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [ADDR_W-1:0]     in_station_address,
  input  logic [IDENT_W-1:0]    in_station_id,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STAT_W-1:0]     out_status,
  output logic [SLOTF_W-1:0]    out_slot_index,
  output logic [COUNTF_W-1:0]   out_active_count,
  output logic [COUNTF_W-1:0]   out_expired_count
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  ptbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptbl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_station_address (in_station_address),
    .in_station_id      (in_station_id),
    .in_now_ms          (in_now_ms),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_active_count   (out_active_count),
    .out_expired_count  (out_expired_count)
  );

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

  // slot index only reported for refresh and insert
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !(out_status == STAT_REFRESH || out_status == STAT_INSERT))
      |-> (out_slot_index == '0))
    else $error("nonzero slot index for a status without a slot");

  // only sweeps expire entries
  a_expired_sweep_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_SWEEP)) |-> (out_expired_count == '0))
    else $error("expired count reported for a hello");

  // a new result only appears from a commit
  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !out_valid && !cmd.commit) |=> !out_valid)
    else $error("result valid without a commit");

endmodule
